/* rtl/fpa_pkg.sv */
// Shared types and constants for the fixed-point ALU.
package fpa_pkg;

    // Raw operand and result width
    localparam int DATA_W = 32;

    // Stream widths
    localparam int S_TDATA_W = 64;
    localparam int S_TUSER_W = 4;
    localparam int M_TDATA_W = 40;

    // Operation codes carried in s_axis_tuser
    typedef enum logic [3:0] {
        OP_ADD      = 4'd0,
        OP_SUB      = 4'd1,
        OP_MUL      = 4'd2,
        OP_DIV      = 4'd3,
        OP_LT       = 4'd4,
        OP_GT       = 4'd5,
        OP_LE       = 4'd6,
        OP_GE       = 4'd7,
        OP_EQ       = 4'd8,
        OP_NE       = 4'd9,
        OP_MIN      = 4'd10,
        OP_MAX      = 4'd11,
        OP_FROM_INT = 4'd12,
        OP_TO_INT   = 4'd13,
        OP_INC      = 4'd14,
        OP_DEC      = 4'd15
    } op_t;

    // Divider result bundle
    typedef struct packed {
        logic [DATA_W-1:0] quot;
        logic              dz;
    } div_res_t;

    // Per-stage side information for the non-unit operations
    typedef struct packed {
        op_t               op;
        logic [DATA_W-1:0] res;
        logic              cmp;
    } side_t;

endpackage

/* rtl/fpa_mul.sv */
// Two-stage signed fixed-point multiplier: full product, then scale and truncate.
module fpa_mul #(
    parameter int FRAC_BITS = 8
) (
    input  logic                              clk,
    input  logic                              en,
    input  logic signed [fpa_pkg::DATA_W-1:0] op_a,
    input  logic signed [fpa_pkg::DATA_W-1:0] op_b,
    output logic        [fpa_pkg::DATA_W-1:0] product
);

    logic signed [2*fpa_pkg::DATA_W-1:0] prod_reg;
    logic        [fpa_pkg::DATA_W-1:0]   res_reg;

    // Stage 1: full 64-bit signed product
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= op_a * op_b;
        end
    end

    // Stage 2: arithmetic shift by the fraction width, keep the low word
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= prod_reg[FRAC_BITS+fpa_pkg::DATA_W-1:FRAC_BITS];
        end
    end

    assign product = res_reg;

endmodule

/* rtl/fpa_div.sv */
// Pipelined signed restoring divider, one quotient bit per stage.
module fpa_div #(
    parameter int FRAC_BITS = 8
) (
    input  logic                              clk,
    input  logic                              en,
    input  logic signed [fpa_pkg::DATA_W-1:0] dividend,
    input  logic signed [fpa_pkg::DATA_W-1:0] divisor,
    output fpa_pkg::div_res_t                 res
);

    localparam int W       = fpa_pkg::DATA_W;
    localparam int DvdBits = W + FRAC_BITS;

    logic [DvdBits-1:0] dvd_reg [DvdBits+1];
    logic [W-1:0]       rem_reg [DvdBits+1];
    logic [W-1:0]       quo_reg [DvdBits+1];
    logic [W-1:0]       dvs_reg [DvdBits+1];
    logic [DvdBits:0]   neg_reg;
    logic [DvdBits:0]   dz_reg;
    fpa_pkg::div_res_t  res_reg;

    logic [W-1:0] mag_a_next;
    logic [W-1:0] mag_b_next;

    // Magnitudes of both operands
    assign mag_a_next = dividend[W-1] ? W'(-dividend) : W'(dividend);
    assign mag_b_next = divisor[W-1]  ? W'(-divisor)  : W'(divisor);

    // Front stage: widen the dividend by the fraction width, record sign and zero divisor
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dvd_reg[0] <= {mag_a_next, {FRAC_BITS{1'b0}}};
            rem_reg[0] <= '0;
            quo_reg[0] <= '0;
            dvs_reg[0] <= mag_b_next;
            neg_reg[0] <= dividend[W-1] ^ divisor[W-1];
            dz_reg[0]  <= (divisor == '0);
        end
    end

    // One restoring step per stage, dividend MSB first
    for (genvar k = 1; k <= DvdBits; k++)
    begin : g_step
        logic [W:0] trial;
        logic [W:0] diff;
        logic       take;

        assign trial = {rem_reg[k-1], dvd_reg[k-1][DvdBits-1]};
        assign diff  = trial - {1'b0, dvs_reg[k-1]};
        assign take  = !diff[W];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= take ? diff[W-1:0] : trial[W-1:0];
                quo_reg[k] <= {quo_reg[k-1][W-2:0], take};
                dvd_reg[k] <= dvd_reg[k-1] << 1;
                dvs_reg[k] <= dvs_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
                dz_reg[k]  <= dz_reg[k-1];
            end
        end
    end

    // Back stage: restore the sign, force zero on a zero divisor
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg.dz <= dz_reg[DvdBits];
            if (dz_reg[DvdBits])
            begin
                res_reg.quot <= '0;
            end
            else if (neg_reg[DvdBits])
            begin
                res_reg.quot <= W'(-quo_reg[DvdBits]);
            end
            else
            begin
                res_reg.quot <= quo_reg[DvdBits];
            end
        end
    end

    assign res = res_reg;

endmodule

/* rtl/fixed_point_alu_unit.sv */
// Top level of the pipelined signed fixed-point ALU with stream ports.
//
// Usage:
//   Input beats arrive on s_axis: tuser carries the operation code, tdata the two
//   raw operands. Each input beat yields exactly one output beat on m_axis, in
//   the order accepted. Results are raw fixed-point values with FRAC_BITS
//   fraction bits, or integers for to_int; comparisons report in a flag bit.
//   Throughput: one beat per cycle while the skid register is free. The
//   pipeline depth is set by the divider, which resolves one quotient bit
//   per stage over 32 + FRAC_BITS stages plus a sign stage on each end.
//   Every operation travels the same depth so that results stay in order.
//   Reset clears all valid bits; no beat is in flight afterwards and the
//   block is ready at once.
//   Stall: an output register and one skid register follow the pipeline.
//   When m_axis_tready is low the pipeline keeps running until the skid
//   register fills, then the whole pipeline holds and s_axis_tready drops.
//   Nothing is lost or repeated.
module fixed_point_alu_unit #(
    parameter int FRAC_BITS = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [31:0] operand_a, [63:32] operand_b
    input  logic [fpa_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // [3:0] req_type
    input  logic [fpa_pkg::S_TUSER_W-1:0]   s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [31:0] result_value, [32] compare_true, [33] divide_by_zero, [39:34] zero
    output logic [fpa_pkg::M_TDATA_W-1:0]   m_axis_tdata
);

    localparam int W       = fpa_pkg::DATA_W;
    localparam int DivBits = W + FRAC_BITS;
    localparam int Lat     = DivBits + 2;
    localparam int MulDly  = Lat - 2;

    logic                en;
    logic signed [W-1:0] op_a;
    logic signed [W-1:0] op_b;
    fpa_pkg::op_t        op_in;
    fpa_pkg::side_t      side_next;

    logic [Lat-1:0]      vld_pipe_reg;
    fpa_pkg::side_t      side_pipe_reg [Lat];
    logic [W-1:0]        mul_pipe_reg  [MulDly];

    logic [W-1:0]        mul_res;
    fpa_pkg::div_res_t   div_res;

    logic                fin_valid;
    logic [W-1:0]        fin_res;
    logic                fin_cmp;
    logic                fin_dz;

    logic                out_valid_reg;
    logic [W-1:0]        out_res_reg;
    logic                out_cmp_reg;
    logic                out_dz_reg;
    logic                skid_valid_reg;
    logic [W-1:0]        skid_res_reg;
    logic                skid_cmp_reg;
    logic                skid_dz_reg;

    // Pipeline advances while the skid register is free
    assign en            = !skid_valid_reg;
    assign s_axis_tready = en;

    assign op_a  = s_axis_tdata[W-1:0];
    assign op_b  = s_axis_tdata[2*W-1:W];
    assign op_in = fpa_pkg::op_t'(s_axis_tuser[3:0]);

    // Arithmetic units
    fpa_mul #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mul (
        .clk     (clk),
        .en      (en),
        .op_a    (op_a),
        .op_b    (op_b),
        .product (mul_res)
    );

    fpa_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk      (clk),
        .en       (en),
        .dividend (op_a),
        .divisor  (op_b),
        .res      (div_res)
    );

    // Operations computed combinationally at entry
    always_comb
    begin
        side_next.op  = op_in;
        side_next.res = '0;
        side_next.cmp = 1'b0;
        case (op_in)
            fpa_pkg::OP_ADD:      side_next.res = W'(op_a + op_b);
            fpa_pkg::OP_SUB:      side_next.res = W'(op_a - op_b);
            fpa_pkg::OP_LT:       side_next.cmp = (op_a <  op_b);
            fpa_pkg::OP_GT:       side_next.cmp = (op_a >  op_b);
            fpa_pkg::OP_LE:       side_next.cmp = (op_a <= op_b);
            fpa_pkg::OP_GE:       side_next.cmp = (op_a >= op_b);
            fpa_pkg::OP_EQ:       side_next.cmp = (op_a == op_b);
            fpa_pkg::OP_NE:       side_next.cmp = (op_a != op_b);
            fpa_pkg::OP_MIN:      side_next.res = (op_a < op_b) ? op_a : op_b;
            fpa_pkg::OP_MAX:      side_next.res = (op_b > op_a) ? op_b : op_a;
            fpa_pkg::OP_FROM_INT: side_next.res = W'(op_a << FRAC_BITS);
            fpa_pkg::OP_TO_INT:   side_next.res = W'(op_a >>> FRAC_BITS);
            fpa_pkg::OP_INC:      side_next.res = W'(op_a + 1);
            fpa_pkg::OP_DEC:      side_next.res = W'(op_a - 1);
            default:              side_next.res = '0;
        endcase
    end

    // Valid bits, matched to the divider depth
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_pipe_reg <= '0;
        end
        else if (en)
        begin
            vld_pipe_reg <= {vld_pipe_reg[Lat-2:0], s_axis_tvalid};
        end
    end

    // Side information and product delay lines
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_pipe_reg[0] <= side_next;
            for (int i = 1; i < Lat; i++)
            begin
                side_pipe_reg[i] <= side_pipe_reg[i-1];
            end
            mul_pipe_reg[0] <= mul_res;
            for (int i = 1; i < MulDly; i++)
            begin
                mul_pipe_reg[i] <= mul_pipe_reg[i-1];
            end
        end
    end

    // Final result select
    assign fin_valid = vld_pipe_reg[Lat-1];
    assign fin_cmp   = side_pipe_reg[Lat-1].cmp;
    assign fin_dz    = (side_pipe_reg[Lat-1].op == fpa_pkg::OP_DIV) && div_res.dz;

    always_comb
    begin
        case (side_pipe_reg[Lat-1].op)
            fpa_pkg::OP_MUL: fin_res = mul_pipe_reg[MulDly-1];
            fpa_pkg::OP_DIV: fin_res = div_res.quot;
            default:         fin_res = side_pipe_reg[Lat-1].res;
        endcase
    end

    // Output register and skid register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (m_axis_tready || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= fin_valid;
            end
        end
        else if (fin_valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Output and skid payload
    always_ff @(posedge clk)
    begin
        if (m_axis_tready || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_res_reg <= skid_res_reg;
                out_cmp_reg <= skid_cmp_reg;
                out_dz_reg  <= skid_dz_reg;
            end
            else
            begin
                out_res_reg <= fin_res;
                out_cmp_reg <= fin_cmp;
                out_dz_reg  <= fin_dz;
            end
        end
        else if (en)
        begin
            skid_res_reg <= fin_res;
            skid_cmp_reg <= fin_cmp;
            skid_dz_reg  <= fin_dz;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(fpa_pkg::M_TDATA_W-W-2){1'b0}}, out_dz_reg, out_cmp_reg,
                            out_res_reg};

    // Skid register only fills behind a held output beat
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register full with no output beat");

    // A drained skid beat shows up on the output next cycle
    a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && m_axis_tready |=>
            m_axis_tvalid && (m_axis_tdata[W-1:0] == $past(skid_res_reg)))
        else $error("skid beat not moved to output");

    // Zero divisor always reports a zero result
    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[W+1] |-> (m_axis_tdata[W-1:0] == '0))
        else $error("divide by zero with nonzero result");

    // Comparison and divide flags never appear together
    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[W] && m_axis_tdata[W+1]))
        else $error("compare and divide flags both set");

endmodule

/* tb/sv/fixed_point_alu_unit_tb.sv */
// Self-checking stream testbench for the pipelined fixed-point ALU.
module fixed_point_alu_unit_tb;

    localparam int FRAC        = 8;
    localparam int PIPE_DEPTH  = FRAC + 34;
    localparam int STALL_LIMIT = 2000;

    // Expected beat on the result side
    typedef struct {
        logic [fpa_pkg::DATA_W-1:0] value;
        logic                       cmp;
        logic                       dz;
        fpa_pkg::op_t               op;
    } alu_result_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    // [31:0] operand_a, [63:32] operand_b
    logic [fpa_pkg::S_TDATA_W-1:0] s_axis_tdata = '0;
    // [3:0] req_type
    logic [fpa_pkg::S_TUSER_W-1:0] s_axis_tuser = fpa_pkg::OP_ADD;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    // [31:0] result_value, [32] compare_true, [33] divide_by_zero, [39:34] zero
    logic [fpa_pkg::M_TDATA_W-1:0] m_axis_tdata;

    alu_result_t pending_results[$];
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          error_count = 0;
    int          results_seen = 0;
    int          zero_divisors = 0;
    int          quiet_cycles = 0;

    fixed_point_alu_unit #(
        .FRAC_BITS     (FRAC)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #2 clk = ~clk;

    // Fixed-point ALU behavior at 64-bit intermediate precision
    function automatic alu_result_t alu_predict(fpa_pkg::op_t op,
                                                logic [fpa_pkg::DATA_W-1:0] ua,
                                                logic [fpa_pkg::DATA_W-1:0] ub);
        longint      sa;
        longint      sb;
        longint      wide;
        alu_result_t r;
        sa      = longint'($signed(ua));
        sb      = longint'($signed(ub));
        r.value = '0;
        r.cmp   = 1'b0;
        r.dz    = 1'b0;
        r.op    = op;
        case (op)
            fpa_pkg::OP_ADD:      r.value = ua + ub;
            fpa_pkg::OP_SUB:      r.value = ua - ub;
            fpa_pkg::OP_MUL:
            begin
                wide    = sa * sb;
                r.value = fpa_pkg::DATA_W'(wide >>> FRAC);
            end
            fpa_pkg::OP_DIV:
            begin
                if (sb == 0)
                begin
                    r.dz = 1'b1;
                end
                else
                begin
                    // signed division truncates toward zero
                    wide    = sa * (longint'(1) << FRAC);
                    r.value = fpa_pkg::DATA_W'(wide / sb);
                end
            end
            fpa_pkg::OP_LT:       r.cmp = (sa < sb);
            fpa_pkg::OP_GT:       r.cmp = (sa > sb);
            fpa_pkg::OP_LE:       r.cmp = (sa <= sb);
            fpa_pkg::OP_GE:       r.cmp = (sa >= sb);
            fpa_pkg::OP_EQ:       r.cmp = (sa == sb);
            fpa_pkg::OP_NE:       r.cmp = (sa != sb);
            fpa_pkg::OP_MIN:      r.value = (sa < sb) ? ua : ub;
            fpa_pkg::OP_MAX:      r.value = (sb > sa) ? ub : ua;
            fpa_pkg::OP_FROM_INT: r.value = ua << FRAC;
            fpa_pkg::OP_TO_INT:   r.value = fpa_pkg::DATA_W'(sa >>> FRAC);
            fpa_pkg::OP_INC:      r.value = ua + 1;
            fpa_pkg::OP_DEC:      r.value = ua - 1;
            default:              r.value = '0;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        error_count++;
        $display("mismatch @%0t: %s", $realtime, msg);
    endtask

    // Present one request beat and hold it until accepted
    task automatic push_request(fpa_pkg::op_t op, logic [fpa_pkg::DATA_W-1:0] a,
                                logic [fpa_pkg::DATA_W-1:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {b, a};
        s_axis_tuser  <= op;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pending_results.push_back(alu_predict(op, a, b));
        if (op == fpa_pkg::OP_DIV && b == '0)
            zero_divisors++;
    endtask

    task automatic stop_sending();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Result side: random back-pressure and in-order field checks
    always @(posedge clk)
    begin
        alu_result_t exp_r;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                report_mismatch($sformatf("unexpected beat tdata=%h", m_axis_tdata));
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (m_axis_tdata[31:0] !== exp_r.value)
                    report_mismatch($sformatf("%s result_value got %h want %h",
                        exp_r.op.name(), m_axis_tdata[31:0], exp_r.value));
                if (m_axis_tdata[32] !== exp_r.cmp)
                    report_mismatch($sformatf("%s compare_true got %b want %b",
                        exp_r.op.name(), m_axis_tdata[32], exp_r.cmp));
                if (m_axis_tdata[33] !== exp_r.dz)
                    report_mismatch($sformatf("%s divide_by_zero got %b want %b",
                        exp_r.op.name(), m_axis_tdata[33], exp_r.dz));
            end
        end
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog: no beat moving on either side for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("timeout: %0d beats still outstanding", pending_results.size());
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // Wraparound, rounding and divide corner cases
    task automatic test_arith_edges();
        push_request(fpa_pkg::OP_ADD, 32'h7fff_ffff, 32'h0000_0001);
        push_request(fpa_pkg::OP_SUB, 32'h8000_0000, 32'h0000_0001);
        push_request(fpa_pkg::OP_MUL, 32'h7fff_ffff, 32'h7fff_ffff);
        push_request(fpa_pkg::OP_MUL, 32'h8000_0000, 32'h8000_0000);
        push_request(fpa_pkg::OP_MUL, 32'hffff_ffff, 32'h0000_0001);
        push_request(fpa_pkg::OP_DIV, 32'h1234_5678, 32'h0000_0000);
        push_request(fpa_pkg::OP_DIV, 32'h8000_0000, 32'hffff_ffff);
        push_request(fpa_pkg::OP_DIV, 32'hffff_ff00, 32'h0000_0003);
        push_request(fpa_pkg::OP_DIV, 32'h0000_0500, 32'hffff_fffe);
    endtask

    // Comparisons, min and max at the signed extremes
    task automatic test_compare_edges();
        push_request(fpa_pkg::OP_LT,  32'h8000_0000, 32'h7fff_ffff);
        push_request(fpa_pkg::OP_GT,  32'h7fff_ffff, 32'h8000_0000);
        push_request(fpa_pkg::OP_LE,  32'hffff_ffff, 32'hffff_ffff);
        push_request(fpa_pkg::OP_GE,  32'h8000_0000, 32'h7fff_ffff);
        push_request(fpa_pkg::OP_EQ,  32'h8000_0000, 32'h8000_0000);
        push_request(fpa_pkg::OP_NE,  32'h0000_0000, 32'h0000_0000);
        push_request(fpa_pkg::OP_MIN, 32'h7fff_ffff, 32'h8000_0000);
        push_request(fpa_pkg::OP_MAX, 32'h8000_0000, 32'h7fff_ffff);
    endtask

    // Conversions and raw increment/decrement
    task automatic test_convert_edges();
        push_request(fpa_pkg::OP_FROM_INT, 32'h0080_0000, 32'hffff_ffff);
        push_request(fpa_pkg::OP_TO_INT,   32'hffff_ffff, 32'h0000_0000);
        push_request(fpa_pkg::OP_TO_INT,   32'h8000_0000, 32'h0000_0000);
        push_request(fpa_pkg::OP_INC,      32'h7fff_ffff, 32'h0000_0000);
        push_request(fpa_pkg::OP_DEC,      32'h8000_0000, 32'hffff_ffff);
    endtask

    function automatic logic [fpa_pkg::DATA_W-1:0] pick_operand();
        logic [fpa_pkg::DATA_W-1:0] v;
        case ($urandom_range(7))
            0:
            begin
                case ($urandom_range(4))
                    0:       v = 32'h8000_0000;
                    1:       v = 32'h7fff_ffff;
                    2:       v = 32'h0000_0000;
                    3:       v = 32'hffff_ffff;
                    default: v = 32'h0000_0001;
                endcase
            end
            1:       v = $urandom_range(1023) - 512;
            2:       v = ($urandom_range(2047) - 1024) << FRAC;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // Random operations with biased operands
    task automatic test_random_mix(int count);
        fpa_pkg::op_t               op;
        logic [fpa_pkg::DATA_W-1:0] a;
        logic [fpa_pkg::DATA_W-1:0] b;
        for (int i = 0; i < count; i++)
        begin
            op = fpa_pkg::op_t'($urandom_range(15));
            a  = pick_operand();
            b  = pick_operand();
            if (op == fpa_pkg::OP_DIV && $urandom_range(7) == 0)
                b = '0;
            else if ($urandom_range(9) == 0)
                b = a;
            push_request(op, a, b);
        end
        stop_sending();
        wait_drained();
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_arith_edges();
        test_compare_edges();
        test_convert_edges();
        stop_sending();
        wait_drained();

        send_idle_pct = 30;
        recv_idle_pct = 45;
        test_random_mix(400);

        send_idle_pct = 45;
        recv_idle_pct = 30;
        test_random_mix(400);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_mix(400);

        repeat (PIPE_DEPTH + 20) @(posedge clk);

        $display("checked %0d result beats over all 16 operations, %0d with a zero divisor",
                 results_seen, zero_divisors);
        $display("idle profiles: sender-heavy, receiver-heavy, none; %0d mismatches",
                 error_count);
        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* files.f */
rtl/fpa_pkg.sv
rtl/fpa_mul.sv
rtl/fpa_div.sv
rtl/fixed_point_alu_unit.sv
tb/sv/fixed_point_alu_unit_tb.sv
